FILE: rtl/core/assert_macros.svh
// Assertion macros used by the median filter controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/mwf_pkg.sv
// Package with constants, command and status types for the median filter.
package mwf_pkg;
    localparam int PIXEL_BITS = 8;
    localparam int MAX_MASK   = 7;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WEFF_W     = 11;
    localparam int HEFF_W     = 13;
    localparam int MSK_W      = 3;
    localparam int HALF_MAX   = (MAX_MASK - 1) >> 1;
    localparam int HALF_W     = 2;
    localparam int SLOT_W     = 3;
    localparam int RAM_DEPTH  = MAX_MASK * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int SORT_N     = MAX_MASK * MAX_MASK;
    localparam int CNT_W      = $clog2(SORT_N + 1);
    localparam int IDX_W      = $clog2(SORT_N);
    localparam int PROD_W     = ROW_W + WEFF_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic cap_in;
        logic px_rd;
        logic px_wr;
        logic mul_need;
        logic mul_have;
        logic gath_start;
        logic gath_issue;
        logic fin_load;
    } mwf_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic win_ready;
        logic gath_done;
        logic out_free;
    } mwf_stat_t;

    // Row modulo seven: octal digits are summed, since eight is one modulo seven.
    function automatic logic [SLOT_W-1:0] row_slot(input logic [ROW_W-1:0] r);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = 5'(r[2:0]) + 5'(r[5:3]) + 5'(r[8:6]) + 5'(r[11:9]);
        t = 4'(s[2:0]) + 4'(s[4:3]);
        u = t[2:0] + 3'(t[3]);
        return (u == 3'd7) ? 3'd0 : u;
    endfunction
endpackage

FILE: rtl/core/mwf_ram.sv
// Generic single-port-write, registered-read RAM.
module mwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/mwf_datapath.sv
// Datapath of the median filter: counters, line store, window gather and sorter.
module mwf_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mwf_pkg::mwf_cmd_t               cmd,
    output mwf_pkg::mwf_stat_t              stat,
    input  logic                            s_func,
    input  logic [mwf_pkg::PIXEL_BITS-1:0]  s_pixel,
    input  logic [mwf_pkg::MSK_W-1:0]       mask_w,
    input  logic [mwf_pkg::MSK_W-1:0]       mask_h,
    input  logic [mwf_pkg::WEFF_W-1:0]      img_w,
    input  logic [mwf_pkg::HEFF_W-1:0]      img_h,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mwf_pkg::PIXEL_BITS-1:0]  m_pixel,
    output logic [mwf_pkg::ROW_W-1:0]       m_row,
    output logic [mwf_pkg::COL_W-1:0]       m_col,
    output logic                            m_last
);
    import mwf_pkg::*;

    logic                  func_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [ROW_W-1:0]      in_row_reg;
    logic [COL_W-1:0]      in_col_reg;
    logic [ROW_W-1:0]      res_row_reg;
    logic [COL_W-1:0]      res_col_reg;
    logic                  frame_done_reg;
    logic [PIXEL_BITS-1:0] evicted_reg [MAX_MASK];
    logic [PROD_W-1:0]     prod_need_reg;
    logic [PROD_W-1:0]     prod_have_reg;
    logic [SLOT_W-1:0]     i_reg;
    logic [SLOT_W-1:0]     j_reg;
    logic                  ins_v_reg;
    logic                  ev_sel_reg;
    logic [PIXEL_BITS-1:0] ev_val_reg;
    logic [PIXEL_BITS-1:0] sort_reg [SORT_N];
    logic [PIXEL_BITS-1:0] sort_next [SORT_N];
    logic [CNT_W-1:0]      sort_cnt_reg;
    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] out_pix_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic                  out_last_reg;

    logic [WEFF_W-1:0]     w_eff;
    logic [HEFF_W-1:0]     h_eff;
    logic [HALF_W-1:0]     hw;
    logic [HALF_W-1:0]     hh;
    logic                  col_wrap;
    logic [COL_W-1:0]      c1;
    logic [ROW_W:0]        r1t;
    logic [ROW_W-1:0]      r1;
    logic [ADDR_W-1:0]     px_addr;
    logic [WEFF_W-1:0]     col_inc;
    logic [ROW_W:0]        row_inc;
    logic [ROW_W:0]        need_rt;
    logic [ROW_W-1:0]      need_r;
    logic [WEFF_W-1:0]     need_ct;
    logic [COL_W-1:0]      need_c;
    logic [ROW_W-1:0]      cr;
    logic [COL_W-1:0]      cc;
    logic [ROW_W:0]        rg_t;
    logic [ROW_W-1:0]      rg;
    logic [WEFF_W-1:0]     cg_t;
    logic [COL_W-1:0]      cg;
    logic                  ev_hit;
    logic [ADDR_W-1:0]     gath_addr;
    logic [ADDR_W-1:0]     raddr;
    logic [PIXEL_BITS-1:0] rdata;
    logic [PIXEL_BITS-1:0] ins_val;
    logic [CNT_W-1:0]      n_total;
    logic [CNT_W-1:0]      med_idx;
    logic [WEFF_W-1:0]     res_col_inc;
    logic [ROW_W:0]        res_row_inc;
    logic [SUM_W-1:0]      sum_need;
    logic [SUM_W-1:0]      sum_have;

    always_comb begin
        if (img_w == '0) w_eff = WEFF_W'(1);
        else if (img_w > WEFF_W'(MAX_WIDTH)) w_eff = WEFF_W'(MAX_WIDTH);
        else w_eff = img_w;
        if (img_h == '0) h_eff = HEFF_W'(1);
        else if (img_h > HEFF_W'(MAX_HEIGHT)) h_eff = HEFF_W'(MAX_HEIGHT);
        else h_eff = img_h;
        hw = ((mask_w >> 1) > MSK_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : HALF_W'(mask_w >> 1);
        hh = ((mask_h >> 1) > MSK_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : HALF_W'(mask_h >> 1);
    end

    // Write position after the deferred wrap of a counter that lies past the size.
    always_comb begin
        col_wrap = {1'b0, in_col_reg} >= w_eff;
        c1       = col_wrap ? '0 : in_col_reg;
        r1t      = {1'b0, in_row_reg} + (ROW_W+1)'(col_wrap);
        r1       = (r1t >= h_eff) ? '0 : r1t[ROW_W-1:0];
        px_addr  = ADDR_W'(row_slot(r1)) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c1);
        col_inc  = {1'b0, c1} + WEFF_W'(1);
        row_inc  = {1'b0, r1} + (ROW_W+1)'(1);
    end

    // Window completeness.
    always_comb begin
        need_rt  = {1'b0, res_row_reg} + (ROW_W+1)'(hh);
        need_r   = (need_rt > h_eff - HEFF_W'(1)) ? ROW_W'(h_eff - HEFF_W'(1))
                                                   : need_rt[ROW_W-1:0];
        need_ct  = {1'b0, res_col_reg} + WEFF_W'(hw);
        need_c   = (need_ct > w_eff - WEFF_W'(1)) ? COL_W'(w_eff - WEFF_W'(1))
                                                   : need_ct[COL_W-1:0];
        sum_need = SUM_W'(prod_need_reg) + SUM_W'(need_c);
        sum_have = SUM_W'(prod_have_reg) + SUM_W'(in_col_reg);
    end

    // Gather address of window tap (i, j) with edge clamping.
    always_comb begin
        cr = ({1'b0, res_row_reg} >= h_eff) ? ROW_W'(h_eff - HEFF_W'(1)) : res_row_reg;
        cc = ({1'b0, res_col_reg} >= w_eff) ? COL_W'(w_eff - WEFF_W'(1)) : res_col_reg;
        rg_t = {1'b0, cr} + (ROW_W+1)'(i_reg);
        if (rg_t < (ROW_W+1)'(hh)) rg_t = '0;
        else rg_t = rg_t - (ROW_W+1)'(hh);
        rg = (rg_t > h_eff - HEFF_W'(1)) ? ROW_W'(h_eff - HEFF_W'(1)) : rg_t[ROW_W-1:0];
        cg_t = {1'b0, cc} + WEFF_W'(j_reg);
        if (cg_t < WEFF_W'(hw)) cg_t = '0;
        else cg_t = cg_t - WEFF_W'(hw);
        cg = (cg_t > w_eff - WEFF_W'(1)) ? COL_W'(w_eff - WEFF_W'(1)) : cg_t[COL_W-1:0];
        ev_hit = ((ROW_W+1)'(rg) + (ROW_W+1)'(MAX_MASK) == {1'b0, in_row_reg})
                 && (cg < in_col_reg) && (cg < COL_W'(MAX_MASK));
        gath_addr = ADDR_W'(row_slot(rg)) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cg);
    end

    assign raddr = cmd.px_rd ? px_addr : gath_addr;

    mwf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RAM_DEPTH)) u_line_store (
        .clk   (aclk),
        .we    (cmd.px_wr),
        .waddr (px_addr),
        .wdata (pix_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Insertion sorter: entries above the new value move up one place.
    assign ins_val = ev_sel_reg ? ev_val_reg : rdata;
    always_comb begin
        for (int p = 0; p < SORT_N; p++) begin
            logic gt_here;
            logic gt_prev;
            gt_here = (CNT_W'(p) < sort_cnt_reg) && (sort_reg[p] > ins_val);
            gt_prev = (p > 0) && (CNT_W'(p) <= sort_cnt_reg)
                      && (sort_reg[(p > 0) ? p - 1 : 0] > ins_val);
            if (gt_prev) sort_next[p] = sort_reg[(p > 0) ? p - 1 : 0];
            else if (gt_here || CNT_W'(p) == sort_cnt_reg) sort_next[p] = ins_val;
            else sort_next[p] = sort_reg[p];
        end
    end

    assign n_total     = CNT_W'({hh, 1'b1}) * CNT_W'({hw, 1'b1});
    assign med_idx     = n_total >> 1;
    assign res_col_inc = {1'b0, res_col_reg} + WEFF_W'(1);
    assign res_row_inc = {1'b0, res_row_reg} + (ROW_W+1)'(1);

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            func_reg <= s_func;
            pix_reg  <= s_pixel;
        end
        if (cmd.px_wr && c1 < COL_W'(MAX_MASK)) begin
            evicted_reg[c1[SLOT_W-1:0]] <= rdata;
        end
        if (cmd.mul_need) prod_need_reg <= need_r * w_eff;
        if (cmd.mul_have) prod_have_reg <= in_row_reg * w_eff;
        if (cmd.gath_issue) begin
            ev_sel_reg <= ev_hit;
            ev_val_reg <= evicted_reg[cg[SLOT_W-1:0]];
        end
        if (ins_v_reg) sort_reg <= sort_next;
        if (cmd.fin_load) begin
            out_pix_reg <= sort_reg[med_idx[IDX_W-1:0]];
            out_row_reg <= res_row_reg;
            out_col_reg <= res_col_reg;
            out_last_reg <= (res_col_inc >= w_eff) && (res_row_inc >= h_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            res_row_reg    <= '0;
            res_col_reg    <= '0;
            frame_done_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            ins_v_reg      <= 1'b0;
            sort_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.px_wr) begin
                if (col_inc >= w_eff) begin
                    in_col_reg <= '0;
                    if (row_inc >= h_eff) begin
                        in_row_reg     <= '0;
                        frame_done_reg <= 1'b1;
                    end else begin
                        in_row_reg <= row_inc[ROW_W-1:0];
                    end
                end else begin
                    in_col_reg <= col_inc[COL_W-1:0];
                    in_row_reg <= r1;
                end
            end
            ins_v_reg <= cmd.gath_issue;
            if (cmd.gath_start) begin
                i_reg        <= '0;
                j_reg        <= '0;
                sort_cnt_reg <= '0;
            end else begin
                if (cmd.gath_issue) begin
                    if (j_reg == SLOT_W'({hw, 1'b0})) begin
                        j_reg <= '0;
                        i_reg <= i_reg + SLOT_W'(1);
                    end else begin
                        j_reg <= j_reg + SLOT_W'(1);
                    end
                end
                if (ins_v_reg) sort_cnt_reg <= sort_cnt_reg + CNT_W'(1);
            end
            if (cmd.fin_load) begin
                out_valid_reg <= 1'b1;
                if (res_col_inc >= w_eff) begin
                    res_col_reg <= '0;
                    if (res_row_inc >= h_eff) begin
                        res_row_reg    <= '0;
                        frame_done_reg <= 1'b0;
                    end else begin
                        res_row_reg <= res_row_inc[ROW_W-1:0];
                    end
                end else begin
                    res_col_reg <= res_col_inc[COL_W-1:0];
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_flush  = (func_reg == FUNC_FLUSH);
    assign stat.win_ready = frame_done_reg || (sum_need < sum_have);
    assign stat.gath_done = (i_reg == SLOT_W'({hh, 1'b0})) && (j_reg == SLOT_W'({hw, 1'b0}));
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_pixel = out_pix_reg;
    assign m_row   = out_row_reg;
    assign m_col   = out_col_reg;
    assign m_last  = out_last_reg;
endmodule

FILE: rtl/core/mwf_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`include "assert_macros.svh"
module mwf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mwf_pkg::mwf_stat_t stat,
    output mwf_pkg::mwf_cmd_t  cmd
);
    import mwf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PX_RD, ST_PX_WR, ST_MUL_A, ST_MUL_B, ST_CHECK,
        ST_G_START, ST_G_ISSUE, ST_G_LAST, ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_PX_RD;
            ST_PX_RD:   state_next = ST_PX_WR;
            ST_PX_WR:   state_next = ST_MUL_A;
            ST_MUL_A:   state_next = ST_MUL_B;
            ST_MUL_B:   state_next = ST_CHECK;
            ST_CHECK:   state_next = stat.win_ready ? ST_G_START : ST_IDLE;
            ST_G_START: state_next = ST_G_ISSUE;
            ST_G_ISSUE: if (stat.gath_done) state_next = ST_G_LAST;
            ST_G_LAST:  state_next = ST_FINISH;
            ST_FINISH:  if (stat.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
        // A flush beat skips the line store write.
        if (state_reg == ST_PX_RD && stat.is_flush) state_next = ST_MUL_A;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.cap_in     = (state_reg == ST_IDLE) && s_valid;
        cmd.px_rd      = (state_reg == ST_PX_RD);
        cmd.px_wr      = (state_reg == ST_PX_WR);
        cmd.mul_need   = (state_reg == ST_MUL_A);
        cmd.mul_have   = (state_reg == ST_MUL_B);
        cmd.gath_start = (state_reg == ST_G_START);
        cmd.gath_issue = (state_reg == ST_G_ISSUE);
        cmd.fin_load   = (state_reg == ST_FINISH) && stat.out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);

    `ASSERT_NEXT(a_cap_enters_rd, aclk, aresetn, cmd.cap_in, state_reg == ST_PX_RD)
    `ASSERT_NEXT(a_gather_ends, aclk, aresetn, cmd.gath_issue && stat.gath_done, state_reg == ST_G_LAST)
    `ASSERT_NEXT(a_no_result_idle, aclk, aresetn, state_reg == ST_CHECK && !stat.win_ready, s_ready)
    `ASSERT_IMPL(a_load_needs_room, aclk, aresetn, cmd.fin_load, stat.out_free && !s_ready)
endmodule

FILE: rtl/core/median_window_filter_unit.sv
// Top level of the streaming odd-window median filter.
//
// Input beats arrive on the s_ channel in raster order of one image plane:
// s_tdata carries the pixel, s_tuser set marks a flush beat that carries no
// pixel and only lets a pending result drain after the last pixel of a plane.
// Each beat yields zero or one result on the m_ channel: the median of the
// edge-clamped window around the next result position, with its row, column
// and tlast on the final result of the plane.
// Configuration goes through the APB port: mask width at 0x0, mask height at
// 0x4, image width at 0x8, image height at 0xC; write only while idle.
// A pixel beat with no result is accepted, the line store is read and written,
// the window-complete test is multiplied out and the decision is made.
// With a result the window taps follow; their number is the window width times
// the window height after even sizes fold up, and they are read from the
// single-read-port line store one per cycle and fed to an insertion sorter.
// A flush beat skips the line store write.
// The result sits in an output register; the next beat is taken while it
// waits, and the block stalls only if a second result is ready before the
// first has been taken. Reset clears counters and control, restores the
// register defaults, and the line store contents stay undefined until written.
module median_window_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mwf_pkg::*;

    localparam logic [1:0] REG_MASK_W = 2'd0;
    localparam logic [1:0] REG_MASK_H = 2'd1;
    localparam logic [1:0] REG_IMG_W  = 2'd2;
    localparam logic [1:0] REG_IMG_H  = 2'd3;

    logic [MSK_W-1:0]      mask_w_reg;
    logic [MSK_W-1:0]      mask_h_reg;
    logic [WEFF_W-1:0]     img_w_reg;
    logic [HEFF_W-1:0]     img_h_reg;
    mwf_cmd_t              cmd;
    mwf_stat_t             stat;
    logic [PIXEL_BITS-1:0] res_pixel;
    logic [ROW_W-1:0]      res_row;
    logic [COL_W-1:0]      res_col;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_w_reg <= MSK_W'(3);
            mask_h_reg <= MSK_W'(3);
            img_w_reg  <= WEFF_W'(640);
            img_h_reg  <= HEFF_W'(480);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_MASK_W: mask_w_reg <= pwdata[MSK_W-1:0];
                REG_MASK_H: mask_h_reg <= pwdata[MSK_W-1:0];
                REG_IMG_W:  img_w_reg  <= pwdata[WEFF_W-1:0];
                REG_IMG_H:  img_h_reg  <= pwdata[HEFF_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MASK_W: prdata = 32'(mask_w_reg);
            REG_MASK_H: prdata = 32'(mask_h_reg);
            REG_IMG_W:  prdata = 32'(img_w_reg);
            REG_IMG_H:  prdata = 32'(img_h_reg);
            default:    prdata = '0;
        endcase
    end

    mwf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mwf_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_func  (s_tuser),
        .s_pixel (s_tdata),
        .mask_w  (mask_w_reg),
        .mask_h  (mask_h_reg),
        .img_w   (img_w_reg),
        .img_h   (img_h_reg),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_pixel (res_pixel),
        .m_row   (res_row),
        .m_col   (res_col),
        .m_last  (m_tlast)
    );

    assign m_tdata = {2'b00, res_col, res_row, res_pixel};
endmodule

FILE: dv/median_window_filter_unit_checker.sv
// Scoreboard for the median filter: predicts each result from the observed beats and compares.
`timescale 1ns / 100ps

module median_window_filter_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding,
    output bit          plane_open,
    output int          pixel_beats,
    output int          flush_beats,
    output int          result_beats
);
    import mwf_pkg::*;

    localparam logic [3:0] ADDR_MASK_W  = 4'h0;
    localparam logic [3:0] ADDR_MASK_H  = 4'h4;
    localparam logic [3:0] ADDR_IMG_W   = 4'h8;
    localparam logic [3:0] ADDR_IMG_H   = 4'hC;

    typedef struct {
        logic [7:0]  pix;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } median_result_t;

    median_result_t medians_due[$];

    logic [7:0] line_mem [0:RAM_DEPTH-1];
    logic [7:0] evicted_px [0:MAX_MASK-1];
    int in_row, in_col, res_row, res_col;
    int cfg_mw, cfg_mh, cfg_iw, cfg_ih;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int eff_w();
        int w;
        w = cfg_iw;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_h();
        int h;
        h = cfg_ih;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic int half_size(input int m);
        return ((m >> 1) > HALF_MAX) ? HALF_MAX : (m >> 1);
    endfunction

    function automatic int clamp_to(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // A row that is being overwritten still answers from the saved copy of its first pixels.
    function automatic int tap_value(input int r, input int c);
        if (c >= MAX_WIDTH) return 0;
        if (r + MAX_MASK == in_row && c < in_col && c < MAX_MASK) return evicted_px[c];
        return line_mem[(r % MAX_MASK) * MAX_WIDTH + c];
    endfunction

    function automatic int window_median(input int ry, input int rx, input int hh, input int hw,
                                         input int w, input int h);
        int taps [0:SORT_N-1];
        int n, k, v;
        n = 0;
        for (int dr = -hh; dr <= hh; dr++) begin
            for (int dc = -hw; dc <= hw; dc++) begin
                v = tap_value(clamp_to(ry + dr, 0, h - 1), clamp_to(rx + dc, 0, w - 1));
                k = n;
                while (k > 0 && taps[k-1] > v) begin
                    taps[k] = taps[k-1];
                    k--;
                end
                taps[k] = v;
                n++;
            end
        end
        return taps[n >> 1];
    endfunction

    task automatic predict_beat(input logic is_flush, input logic [7:0] px);
        int w, h, hw, hh, slot, need_r, need_c, ry, rx;
        bit ready;
        median_result_t res;
        w  = eff_w();
        h  = eff_h();
        hw = half_size(cfg_mw);
        hh = half_size(cfg_mh);
        if (is_flush == FUNC_PIXEL) begin
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (in_row >= h) in_row = 0;
            slot = (in_row % MAX_MASK) * MAX_WIDTH + in_col;
            if (in_col < MAX_MASK) evicted_px[in_col] = line_mem[slot];
            line_mem[slot] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row = 0;
                    plane_open = 1'b1;
                end
            end
        end
        ry = res_row;
        rx = res_col;
        need_r = (ry + hh > h - 1) ? h - 1 : ry + hh;
        need_c = (rx + hw > w - 1) ? w - 1 : rx + hw;
        ready = plane_open ||
                (longint'(need_r) * w + need_c < longint'(in_row) * w + in_col);
        if (!ready) return;
        res.pix  = 8'(window_median(clamp_to(ry, 0, h - 1), clamp_to(rx, 0, w - 1),
                                    hh, hw, w, h));
        res.row  = 12'(ry);
        res.col  = 10'(rx);
        res.last = 1'b0;
        res_col++;
        if (res_col >= w) begin
            res_col = 0;
            res_row++;
            if (res_row >= h) begin
                res_row    = 0;
                res.last   = 1'b1;
                plane_open = 1'b0;
            end
        end
        medians_due = {medians_due, res};
    endtask

    always @(posedge aclk) begin
        median_result_t want;
        if (!aresetn) begin
            medians_due.delete();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (evicted_px[i]) evicted_px[i] = '0;
            in_row = 0; in_col = 0; res_row = 0; res_col = 0;
            plane_open = 1'b0;
            cfg_mw = 3; cfg_mh = 3; cfg_iw = 640; cfg_ih = 480;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_MASK_W: cfg_mw = pwdata[2:0];
                    ADDR_MASK_H: cfg_mh = pwdata[2:0];
                    ADDR_IMG_W:  cfg_iw = pwdata[10:0];
                    ADDR_IMG_H:  cfg_ih = pwdata[12:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_FLUSH) flush_beats++;
                else pixel_beats++;
                predict_beat(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                result_beats++;
                if (medians_due.size() == 0) begin
                    // More result beats than predicted results.
                    report_mismatch("result count", result_beats, result_beats - 1);
                end else begin
                    want = medians_due.pop_front();
                    if (m_tdata[7:0] !== want.pix) report_mismatch("pixel_out", m_tdata[7:0], want.pix);
                    if (m_tdata[19:8] !== want.row) report_mismatch("out_row", m_tdata[19:8], want.row);
                    if (m_tdata[29:20] !== want.col) report_mismatch("out_col", m_tdata[29:20], want.col);
                    if (m_tlast !== want.last) report_mismatch("tlast", m_tlast, want.last);
                end
            end
        end
        outstanding = medians_due.size();
    end

    initial begin
        fail_count = 0; outstanding = 0; plane_open = 0;
        pixel_beats = 0; flush_beats = 0; result_beats = 0;
    end
endmodule

FILE: dv/median_window_filter_unit_test.sv
// Testbench top: clock, reset, stimulus for the median filter and the final verdict.
`timescale 1ns / 100ps

module median_window_filter_unit_test;
    import mwf_pkg::*;

    localparam int STALL_LIMIT  = 20000;  // cycles with no beat on any port
    localparam int SETTLE_WAIT  = 90;
    localparam int RANDOM_ITEMS = 820;    // input beats in the random part
    localparam int WIDE_ITEMS   = 64;

    localparam logic [3:0] REG_MASK_W = 4'h0;
    localparam logic [3:0] REG_MASK_H = 4'h4;
    localparam logic [3:0] REG_IMG_W  = 4'h8;
    localparam logic [3:0] REG_IMG_H  = 4'hC;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = FUNC_PIXEL;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  fail_count, outstanding, pixel_beats, flush_beats, result_beats;
    bit  plane_open;

    // Idle percentages per side and a long hold-off for the receiver.
    int  sender_idle_pct   = 7;
    int  receiver_idle_pct = 80;
    int  receiver_hold     = 0;
    int  planes_run        = 0;
    int  quiet_cycles      = 0;

    median_window_filter_unit DUT (.*);

    median_window_filter_unit_checker scoreboard (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The receiver either sits out a requested hold-off or stalls at random.
    always @(negedge aclk) begin
        if (receiver_hold > 0) begin
            receiver_hold = receiver_hold - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog: any beat on the stream ports or a register access keeps the run alive.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // APB write: setup cycle, then the access cycle that commits at the next rising edge.
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // One input beat. Returns just after the accepting edge, once the scoreboard has settled.
    task automatic send_beat(input logic func, input logic [7:0] px);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        #1;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Waits until every predicted result has come out, then lets a flush-only tail settle.
    task automatic wait_idle();
        stop_sending();
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic configure(input int mw, input int mh, input int iw, input int ih);
        wait_idle();
        write_reg(REG_MASK_W, mw);
        write_reg(REG_MASK_H, mh);
        write_reg(REG_IMG_W, iw);
        write_reg(REG_IMG_H, ih);
    endtask

    // Streams one plane of random pixels with an occasional stray flush. With drain set,
    // flush beats follow until the plane's last result has been predicted.
    task automatic stream_plane(input int w, input int h, input bit drain, input int noise_pct);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_beat(FUNC_FLUSH, 8'($urandom));
            send_beat(FUNC_PIXEL, 8'($urandom));
        end
        if (drain) begin
            while (plane_open) send_beat(FUNC_FLUSH, 8'($urandom));
        end
        planes_run++;
    endtask

    initial begin
        int mw, mh, iw, ih, budget, start_beats;
        bit held;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. A flush before any pixel finds no window ready and yields nothing.
        send_beat(FUNC_FLUSH, 8'hFF);
        // Single pixel plane with a one-by-one window.
        configure(1, 1, 1, 1);
        send_beat(FUNC_PIXEL, 8'h00);
        // Largest window over a tiny plane: taps beyond the plane clamp to the edges.
        configure(7, 7, 3, 2);
        send_beat(FUNC_PIXEL, 8'hFF);
        send_beat(FUNC_PIXEL, 8'h00);
        send_beat(FUNC_PIXEL, 8'hFF);
        send_beat(FUNC_PIXEL, 8'hAA);
        send_beat(FUNC_PIXEL, 8'h55);
        send_beat(FUNC_PIXEL, 8'h00);
        while (plane_open) send_beat(FUNC_FLUSH, 8'h00);
        // Even and zero mask sizes fold up to the next odd size; a zero height acts as one row.
        configure(2, 0, 5, 0);
        stream_plane(5, 1, 1, 0);
        // Even mask codes and a height register at its top value, then back in range.
        configure(6, 4, 4, 8191);
        write_reg(REG_IMG_H, 2);
        stream_plane(4, 2, 1, 0);

        // Random part, in three idling phases.
        start_beats = pixel_beats + flush_beats;
        held = 1'b0;
        budget = 0;
        while (budget < RANDOM_ITEMS) begin
            if (budget > 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct = 0; receiver_idle_pct = 0;
            end else if (budget > RANDOM_ITEMS / 3) begin
                sender_idle_pct = 80; receiver_idle_pct = 7;
            end
            mw = $urandom_range(0, 7);
            mh = $urandom_range(0, 7);
            iw = $urandom_range(1, 12);
            ih = $urandom_range(1, 10);
            if ($urandom_range(0, 5) == 0) ih = $urandom_range(8, 14);
            configure(mw, mh, iw, ih);
            // One long output hold while a plane of several pixels keeps coming in.
            if (!held && planes_run >= 8 && iw * ih >= 8) begin
                receiver_hold = 400;
                held = 1'b1;
            end
            stream_plane(iw, ih, $urandom_range(0, 4) != 0, 5);
            // Occasionally a second plane starts before the first one has drained.
            if (plane_open) stream_plane(iw, ih, 1, 5);
            budget = pixel_beats + flush_beats - start_beats;
        end

        // Width register above the line length: rows saturate to MAX_WIDTH, so a short
        // run of pixels leaves the row open and only completed windows come out.
        sender_idle_pct = 0; receiver_idle_pct = 0;
        configure(7, 1, 2047, 1);
        for (int i = 0; i < WIDE_ITEMS; i++) send_beat(FUNC_PIXEL, 8'($urandom));

        wait_idle();
        $display("Covered %0d pixel beats, %0d flush beats and %0d results over %0d planes,",
                 pixel_beats, flush_beats, result_beats, planes_run);
        $display("with mask codes 0..7, clamped borders, early restarts and a long output hold.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mwf_pkg.sv
rtl/core/mwf_ram.sv
rtl/core/mwf_datapath.sv
rtl/core/mwf_ctrl.sv
rtl/core/median_window_filter_unit.sv
dv/median_window_filter_unit_checker.sv
dv/median_window_filter_unit_test.sv
